// ===== hw/rtl/dial_code_lock_macros.svh =====
// Assertion macros shared by the dial code lock RTL.
`ifndef DIAL_CODE_LOCK_MACROS_SVH
`define DIAL_CODE_LOCK_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while reset is asserted.
`define DCL_ASSERT(label, clk_i, rst_ni, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("dial_code_lock: check failed");

// Clocked check that also holds during reset.
`define DCL_ASSERT_ALWAYS(label, clk_i, prop) \
	label: assert property (@(posedge clk_i) (prop)) \
		else $error("dial_code_lock: check failed");

`else

`define DCL_ASSERT(label, clk_i, rst_ni, prop)
`define DCL_ASSERT_ALWAYS(label, clk_i, prop)

`endif

`endif

// ===== hw/rtl/dcl_pkg.sv =====
// Types, codes and defaults for the dial code lock.
package dcl_pkg;

	localparam int CODE_LENGTH_DEF = 4;
	localparam int DIGIT_COUNT_DEF = 10;
	localparam int SAMPLE_BITS_DEF = 10;

	// number of code digits that have a secret register
	localparam int SECRET_COUNT = 4;

	localparam logic [3:0] SECRET_RST_0    = 4'd1;
	localparam logic [3:0] SECRET_RST_1    = 4'd2;
	localparam logic [3:0] SECRET_RST_2    = 4'd3;
	localparam logic [3:0] SECRET_RST_3    = 4'd4;
	localparam logic [3:0] LIMIT_RST       = 4'd3;
	localparam logic [5:0] DEAD_BAND_RST   = 6'd25;

	typedef enum logic [2:0] {
		REG_SECRET_0  = 3'd0,
		REG_SECRET_1  = 3'd1,
		REG_SECRET_2  = 3'd2,
		REG_SECRET_3  = 3'd3,
		REG_LIMIT     = 3'd4,
		REG_DEAD_BAND = 3'd5
	} dcl_reg_t;

	typedef enum logic [4:0] {
		MODE_IDLE     = 5'b00001,
		MODE_ENTERING = 5'b00010,
		MODE_OPEN     = 5'b00100,
		MODE_WRONG    = 5'b01000,
		MODE_LOCKED   = 5'b10000
	} dcl_mode_t;

	localparam logic [2:0] LS_IDLE     = 3'd0;
	localparam logic [2:0] LS_ENTERING = 3'd1;
	localparam logic [2:0] LS_OPEN     = 3'd2;
	localparam logic [2:0] LS_WRONG    = 3'd3;
	localparam logic [2:0] LS_LOCKED   = 3'd4;

	function automatic logic [2:0] lock_code(input dcl_mode_t mode);
		logic [2:0] code;
		unique case (mode)
			MODE_IDLE:     code = LS_IDLE;
			MODE_ENTERING: code = LS_ENTERING;
			MODE_OPEN:     code = LS_OPEN;
			MODE_WRONG:    code = LS_WRONG;
			MODE_LOCKED:   code = LS_LOCKED;
			default:       code = LS_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== hw/rtl/dial_code_lock.sv =====
// Dial code lock: quantizes a dial sample, collects digits on button release, checks the code.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (6 regs, others ignored)
//  in      | in_valid / in_ready    | adc_sample, button_level
//  out     | out_valid / out_ready  | lock_state, current_digit, digits_entered,
//          |                        | wrong_count
//
// One request per cycle sustained while results are taken. A request is held in
// the input register, then the quantizer and lock update run in a single pass into
// the state registers, which are the result. out_valid rises as the state registers load.
// The output stage only stalls the input register while a result waits; a new request
// is taken in the same cycle the waiting result is taken. cfg_ready is always high.
// Reset restores the register defaults, idle mode, no digit and a zero wrong count;
// lockout lasts until reset.
module dial_code_lock #(
	parameter int CODE_LENGTH = dcl_pkg::CODE_LENGTH_DEF,
	parameter int DIGIT_COUNT = dcl_pkg::DIGIT_COUNT_DEF,
	parameter int SAMPLE_BITS = dcl_pkg::SAMPLE_BITS_DEF,
	parameter int DIGIT_BITS  = $clog2(DIGIT_COUNT + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [5:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                   button_level,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             lock_state,
	output logic [DIGIT_BITS-1:0]  current_digit,
	output logic [1:0]             digits_entered,
	output logic [3:0]             wrong_count
);
	import dcl_pkg::*;

`include "dial_code_lock_macros.svh"

	localparam int                   W         = SAMPLE_BITS;
	localparam logic [W-1:0]         FULL      = {W{1'b1}};
	localparam int                   STEP      = ((1 << W) - 1) / DIGIT_COUNT;
	localparam int                   QW        = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int                   IDX_W     = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam int                   CMP_W     = (DIGIT_BITS > 4) ? DIGIT_BITS : 4;
	localparam logic [IDX_W-1:0]     IDX_LAST  = IDX_W'(CODE_LENGTH - 1);
	localparam logic [DIGIT_BITS-1:0] NO_DIGIT = DIGIT_BITS'(DIGIT_COUNT);
	localparam logic [DIGIT_BITS-1:0] TOP_DIGIT = DIGIT_BITS'(DIGIT_COUNT - 1);

	// configuration registers
	logic [3:0] secret_q [SECRET_COUNT];
	logic [3:0] limit_q;
	logic [5:0] dead_band_q;

	// input register
	logic         valid_s1;
	logic [W-1:0] sample_s1;
	logic         level_s1;

	// lock state, doubles as the result register
	dcl_mode_t             mode_q;
	logic [DIGIT_BITS-1:0] stable_q;
	logic [DIGIT_BITS-1:0] entered_q [CODE_LENGTH];
	logic [IDX_W-1:0]      idx_q;
	logic                  held_q;
	logic [3:0]            wrong_q;
	logic                  out_valid_q;

	logic adv;

	//--------------------------------------------------------------------------
	// Handshakes: the input register moves on when the result slot is free or
	// being drained this cycle.
	//--------------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_q[0] <= SECRET_RST_0;
			secret_q[1] <= SECRET_RST_1;
			secret_q[2] <= SECRET_RST_2;
			secret_q[3] <= SECRET_RST_3;
			limit_q     <= LIMIT_RST;
			dead_band_q <= DEAD_BAND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SECRET_0:  secret_q[0] <= cfg_data[3:0];
				REG_SECRET_1:  secret_q[1] <= cfg_data[3:0];
				REG_SECRET_2:  secret_q[2] <= cfg_data[3:0];
				REG_SECRET_3:  secret_q[3] <= cfg_data[3:0];
				REG_LIMIT:     limit_q     <= cfg_data[3:0];
				REG_DEAD_BAND: dead_band_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= adc_sample;
			level_s1  <= button_level;
		end
	end

	//--------------------------------------------------------------------------
	// Quantizer. The band index is the count of band thresholds at or below the
	// sample, which also clamps the short leftover band at full scale into the
	// top band. The digit is taken only inside the band trimmed by dead_band.
	//--------------------------------------------------------------------------
	logic [QW-1:0]         band;
	logic [W-1:0]          band_bot;
	logic [W-1:0]          band_top;
	logic [W:0]            db_ext;
	logic                  in_band;
	logic [DIGIT_BITS-1:0] digit_nxt;

	always_comb begin
		band = '0;
		for (int k = 1; k < DIGIT_COUNT; k++) begin
			if (sample_s1 >= W'(k * STEP))
				band = QW'(k);
		end
	end

	always_comb begin
		band_bot = '0;
		band_top = FULL;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			if (band == QW'(k)) begin
				band_bot = W'(k * STEP);
				band_top = (k == DIGIT_COUNT - 1) ? FULL : W'((k + 1) * STEP - 1);
			end
		end
	end

	assign db_ext  = (W + 1)'(dead_band_q);
	// sample + margin <= top stands in for sample <= top - margin
	assign in_band = ({1'b0, band_top} >= db_ext)
		&& ({1'b0, sample_s1} >= {1'b0, band_bot} + db_ext)
		&& ({1'b0, sample_s1} + db_ext <= {1'b0, band_top});
	assign digit_nxt = in_band ? (TOP_DIGIT - DIGIT_BITS'(band)) : stable_q;

	//--------------------------------------------------------------------------
	// Lock update
	//--------------------------------------------------------------------------
	logic       release_ev;
	logic       last_digit;
	logic       code_ok;
	logic [3:0] wrong_inc;
	dcl_mode_t  mode_dial;
	dcl_mode_t  mode_nxt;
	logic [IDX_W-1:0] idx_nxt;
	logic [3:0] wrong_nxt;

	assign release_ev = level_s1 && held_q;
	assign last_digit = (idx_q == IDX_LAST);

	// the digit stored by this release sits at the last position
	always_comb begin
		logic [CMP_W-1:0] have;
		logic [CMP_W-1:0] want;
		code_ok = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			have = (i == CODE_LENGTH - 1) ? CMP_W'(digit_nxt) : CMP_W'(entered_q[i]);
			want = (i < SECRET_COUNT) ? CMP_W'(secret_q[i]) : '0;
			if (have != want)
				code_ok = 1'b0;
		end
	end

	assign wrong_inc = (wrong_q < limit_q) ? wrong_q + 4'd1 : wrong_q;

	always_comb begin
		mode_dial = mode_q;
		if (digit_nxt != stable_q && mode_q == MODE_IDLE)
			mode_dial = MODE_ENTERING;

		mode_nxt  = mode_dial;
		idx_nxt   = idx_q;
		wrong_nxt = wrong_q;
		if (release_ev) begin
			priority if (mode_dial == MODE_ENTERING) begin
				if (last_digit) begin
					idx_nxt = '0;
					if (code_ok) begin
						mode_nxt = MODE_OPEN;
					end else begin
						wrong_nxt = wrong_inc;
						mode_nxt  = (wrong_inc >= limit_q) ? MODE_LOCKED : MODE_WRONG;
					end
				end else begin
					idx_nxt = idx_q + IDX_W'(1);
				end
			end else if (mode_dial == MODE_OPEN || mode_dial == MODE_WRONG) begin
				mode_nxt = MODE_IDLE;
			end else begin
				mode_nxt = mode_dial;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			stable_q    <= NO_DIGIT;
			idx_q       <= '0;
			held_q      <= 1'b0;
			wrong_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				mode_q   <= mode_nxt;
				stable_q <= digit_nxt;
				idx_q    <= idx_nxt;
				held_q   <= !level_s1;
				wrong_q  <= wrong_nxt;
			end
			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// digit store has no reset; a position is read only after this entry wrote it
	always_ff @(posedge clk) begin
		if (adv && release_ev && mode_dial == MODE_ENTERING)
			entered_q[idx_q] <= digit_nxt;
	end

	assign out_valid      = out_valid_q;
	assign lock_state     = lock_code(mode_q);
	assign current_digit  = stable_q;
	assign digits_entered = 2'(idx_q);
	assign wrong_count    = wrong_q;

	//--------------------------------------------------------------------------
	// Checks
	//--------------------------------------------------------------------------
	`DCL_ASSERT(a_mode_onehot, clk, arst_n, $onehot(mode_q))
	`DCL_ASSERT(a_lockout_sticky, clk, arst_n, mode_q == MODE_LOCKED |=> mode_q == MODE_LOCKED)
	`DCL_ASSERT(a_state_holds_on_stall, clk, arst_n, !adv |=> $stable(mode_q) && $stable(idx_q))
	`DCL_ASSERT(a_wrong_steps_by_one, clk, arst_n, wrong_q == $past(wrong_q) || wrong_q == $past(wrong_q) + 4'd1)
	`DCL_ASSERT(a_index_in_range, clk, arst_n, idx_q <= IDX_LAST)

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for dial_code_lock: scripted and random dial/button requests vs a model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcl_pkg::*;

	localparam int BAND_WIDTH     = 1023 / 10;	// width of one digit band
	localparam int NO_DIGIT       = 10;		// current_digit before any stable reading
	localparam int SQUEEZE_CYCLES = 160;		// long receiver hold-off
	localparam int WATCHDOG_LIMIT = 3000;		// cycles with no handshake at all

	// programmable lock settings, mirrored from what was written on the cfg port
	typedef struct packed {
		logic [3:0][3:0] secret;
		logic [3:0]      limit;
		logic [5:0]      band;
	} lock_cfg_t;

	// lock state as the bench tracks it
	typedef struct packed {
		logic [2:0]      mode;
		logic [3:0]      digit;
		logic [3:0][3:0] code;
		logic [2:0]      idx;
		logic            held;
		logic [3:0]      tally;
	} lock_st_t;

	typedef struct packed {
		logic [9:0] sample;
		logic       level;
	} dial_req_t;

	// what the block reports after one request
	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] digit;
		logic [1:0] idx;
		logic [3:0] tally;
	} lock_view_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [9:0] adc_sample = '0;
	logic       button_level = 1'b1;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] lock_state;
	logic [3:0] current_digit;
	logic [1:0] digits_entered;
	logic [3:0] wrong_count;

	dial_code_lock u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.adc_sample     (adc_sample),
		.button_level   (button_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.lock_state     (lock_state),
		.current_digit  (current_digit),
		.digits_entered (digits_entered),
		.wrong_count    (wrong_count)
	);

	always #10 clk = ~clk;

	lock_cfg_t  lock_cfg;
	lock_st_t   plan_st;		// state as the stimulus generator expects it to be
	lock_st_t   track_st;		// state advanced on each accepted request
	dial_req_t  pending_reqs[$];
	lock_view_t results_due[$];
	lock_view_t due;

	int  made_reqs = 0;
	int  errors = 0;
	int  burst_odds = 0;		// percent chance of an idle burst, 0 means none
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  squeeze_asked = 0;
	int  squeeze_taken = 0;
	int  idle_cycles = 0;
	bit  lockout_ok = 1'b0;		// only the last phase may lock the block out
	bit  force_wrong = 1'b0;
	logic in_fire = 1'b0;

	// ------------------------------------------------------------------
	// Model of the lock
	// ------------------------------------------------------------------

	// Quantize a dial sample; samples in the dead band keep the held digit.
	function automatic logic [3:0] dial_digit(input logic [9:0] sample, input logic [3:0] held,
			input logic [5:0] band);
		int s, b, q, top;
		s = sample;
		b = band;
		q = s / BAND_WIDTH;
		if (q > 9)
			q = 9;
		top = (q == 9) ? 1023 : (q + 1) * BAND_WIDTH - 1;
		// band narrowed to nothing: never accepts
		if (top < b)
			return held;
		if (s >= q * BAND_WIDTH + b && s <= top - b)
			return 4'(9 - q);
		return held;
	endfunction

	function automatic lock_st_t lock_step(input lock_st_t s, input lock_cfg_t c,
			input logic [9:0] sample, input logic level);
		lock_st_t n;
		logic [3:0] d;
		n = s;
		d = dial_digit(sample, s.digit, c.band);
		if (d != n.digit) begin
			// any digit change wakes the lock from idle
			if (n.mode == LS_IDLE)
				n.mode = LS_ENTERING;
			n.digit = d;
		end
		if (!level) begin
			n.held = 1'b1;
		end else if (n.held) begin
			// button release
			n.held = 1'b0;
			if (n.mode == LS_ENTERING) begin
				n.code[n.idx[1:0]] = n.digit;
				n.idx = n.idx + 3'd1;
				if (n.idx == 3'd4) begin
					// the completing release does not also dismiss the verdict
					if (n.code == c.secret) begin
						n.mode = LS_OPEN;
					end else begin
						// tally saturates; a lowered limit locks out without counting
						if (n.tally < c.limit)
							n.tally = n.tally + 4'd1;
						n.mode = (n.tally >= c.limit) ? LS_LOCKED : LS_WRONG;
					end
					n.idx = 3'd0;
				end
			end else if (n.mode == LS_OPEN || n.mode == LS_WRONG) begin
				n.mode = LS_IDLE;
			end
		end
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	// A sample that reads as digit d under the current dead band, or any sample when none can.
	function automatic logic [9:0] band_sample(input logic [3:0] d, input logic [5:0] band);
		int q, lo, hi;
		if (d > 9)
			return 10'($urandom_range(0, 1023));
		q = 9 - d;
		lo = q * BAND_WIDTH + band;
		hi = ((q == 9) ? 1023 : (q + 1) * BAND_WIDTH - 1) - band;
		if (lo > hi)
			return 10'($urandom_range(0, 1023));
		return 10'($urandom_range(lo, hi));
	endfunction

	// Queue one request. Unless a wrong code is wanted here, a release that would count
	// a wrong code (or lock out before the last phase) becomes a press instead, so the
	// wrong-code budget lasts the whole run.
	task automatic push_req(input logic [9:0] sample, input logic level, input bit may_fail);
		lock_st_t trial;
		trial = lock_step(plan_st, lock_cfg, sample, level);
		if ((trial.mode == LS_LOCKED && !lockout_ok) ||
				(trial.tally != plan_st.tally && !may_fail)) begin
			level = 1'b0;
			trial = lock_step(plan_st, lock_cfg, sample, level);
		end
		plan_st = trial;
		pending_reqs.push_back('{sample: sample, level: level});
		made_reqs++;
	endtask

	// Turn to digit d, settle there, press and release.
	task automatic dial_in(input logic [3:0] d, input bit may_fail);
		int n;
		if ($urandom_range(0, 3) == 0)
			push_req(10'($urandom_range(0, 1023)), 1'b1, may_fail);	// dial passing by
		n = $urandom_range(1, 3);
		repeat (n) push_req(band_sample(d, lock_cfg.band), 1'b1, may_fail);
		n = $urandom_range(1, 2);
		repeat (n) push_req(band_sample(d, lock_cfg.band), 1'b0, may_fail);
		push_req(band_sample(d, lock_cfg.band), 1'b1, may_fail);
	endtask

	// Enter the rest of a code, mostly the right one.
	task automatic enter_code();
		bit wrong;
		int bad_pos, guard;
		logic [3:0] d;
		wrong = force_wrong ||
			(($urandom_range(0, 99) < 15) && (plan_st.tally + 1 < lock_cfg.limit));
		bad_pos = $urandom_range(0, 3);
		guard = 0;
		while (plan_st.mode == LS_ENTERING && guard < 6) begin
			d = lock_cfg.secret[plan_st.idx[1:0]];
			if (wrong && plan_st.idx == bad_pos)
				d = 4'((d + $urandom_range(1, 9)) % 10);
			dial_in(d, wrong);
			guard++;
			// now and then walk away halfway; a later session resumes
			if ($urandom_range(0, 19) == 0)
				break;
		end
	endtask

	task automatic noise_burst();
		int n;
		bit loose;
		logic lvl;
		n = $urandom_range(1, 6);
		repeat (n) begin
			// random presses during entry only while wrong codes are still affordable
			loose = plan_st.mode != LS_ENTERING || plan_st.tally + 2 < lock_cfg.limit;
			lvl = loose ? 1'($urandom_range(0, 1)) : 1'b1;
			push_req(10'($urandom_range(0, 1023)), lvl, loose && plan_st.mode == LS_ENTERING);
		end
	endtask

	// One user interaction, picked from where the lock stands.
	task automatic lock_session();
		logic [3:0] d;
		case (plan_st.mode)
			LS_IDLE: begin
				if (plan_st.held)
					push_req(band_sample(plan_st.digit, lock_cfg.band), 1'b1, 1'b0);
				d = 4'($urandom_range(0, 9));
				if (d == plan_st.digit)
					d = 4'((d + 1) % 10);
				push_req(band_sample(d, lock_cfg.band), 1'b1, 1'b0);
				enter_code();
			end
			LS_ENTERING: begin
				enter_code();
			end
			LS_OPEN, LS_WRONG: begin
				if ($urandom_range(0, 3) == 0)
					noise_burst();
				push_req(10'($urandom_range(0, 1023)), 1'b0, 1'b0);
				push_req(10'($urandom_range(0, 1023)), 1'b1, 1'b0);
			end
			default: begin
				noise_burst();
			end
		endcase
	endtask

	// Wait until every request is in and every result is out, plus pipeline slack.
	task automatic settle(input int slack);
		while (pending_reqs.size() > 0 || in_valid || results_due.size() > 0)
			@(posedge clk);
		repeat (slack) @(posedge clk);
	endtask

	task automatic run_phase(input int count);
		int goal;
		goal = made_reqs + count;
		while (made_reqs < goal) begin
			if ($urandom_range(0, 99) < 75)
				lock_session();
			else
				noise_burst();
		end
		settle(4);
	endtask

	task automatic write_reg(input dcl_reg_t idx, input logic [5:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LIMIT:     lock_cfg.limit = val[3:0];
			REG_DEAD_BAND: lock_cfg.band = val;
			default:       lock_cfg.secret[idx[1:0]] = val[3:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_lock(input logic [3:0] s0, input logic [3:0] s1,
			input logic [3:0] s2, input logic [3:0] s3, input logic [3:0] limit,
			input logic [5:0] band);
		write_reg(REG_SECRET_0, 6'(s0));
		write_reg(REG_SECRET_1, 6'(s1));
		write_reg(REG_SECRET_2, 6'(s2));
		write_reg(REG_SECRET_3, 6'(s3));
		write_reg(REG_LIMIT, 6'(limit));
		write_reg(REG_DEAD_BAND, band);
	endtask

	// ------------------------------------------------------------------
	// Request driver: one request held on the port until taken
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			idle_cycles <= 0;
		end else begin
			in_fire <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("t=%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	always @(negedge clk) begin
		if (in_fire) begin
			// payload is still the one taken at the last rising edge
			track_st = lock_step(track_st, lock_cfg, adc_sample, button_level);
			results_due.push_back('{mode: track_st.mode, digit: track_st.digit,
				idx: track_st.idx[1:0], tally: track_st.tally});
		end
		if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (arst_n && pending_reqs.size() > 0) begin
				adc_sample <= pending_reqs[0].sample;
				button_level <= pending_reqs[0].level;
				void'(pending_reqs.pop_front());
				in_valid <= 1'b1;
				if (burst_odds > 0 && $urandom_range(1, 100) <= burst_odds)
					gap_left <= $urandom_range(1, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold-off on request
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (squeeze_taken != squeeze_asked) begin
			squeeze_taken <= squeeze_asked;
			hold_left <= SQUEEZE_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (burst_odds > 0 && $urandom_range(1, 100) <= burst_odds) begin
			stall_left <= $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("t=%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("t=%0t: unexpected result, expected none, got %0d/%0d/%0d/%0d",
					$time, lock_state, current_digit, digits_entered, wrong_count);
				errors++;
			end else begin
				due = results_due.pop_front();
				check_field("lock_state", due.mode, lock_state);
				check_field("current_digit", due.digit, current_digit);
				check_field("digits_entered", due.idx, digits_entered);
				check_field("wrong_count", due.tally, wrong_count);
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		int lim_lo;
		lock_cfg.secret = {SECRET_RST_3, SECRET_RST_2, SECRET_RST_1, SECRET_RST_0};
		lock_cfg.limit = LIMIT_RST;
		lock_cfg.band = DEAD_BAND_RST;
		plan_st = '{mode: LS_IDLE, digit: 4'(NO_DIGIT), code: '0, idx: '0, held: 1'b0,
			tally: '0};
		track_st = plan_st;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset code 1-2-3-4 with dead band 25, band edges and scale ends.
		burst_odds = 15;
		push_req(10'd0, 1'b1, 1'b0);		// bottom of scale, inside dead band
		push_req(10'd1023, 1'b0, 1'b0);	// top of scale, inside dead band, press
		push_req(10'd840, 1'b1, 1'b0);	// one below digit 1 window, release in idle
		push_req(10'd841, 1'b1, 1'b0);	// digit 1 window low edge, starts entry
		push_req(10'd892, 1'b0, 1'b0);
		push_req(10'd892, 1'b1, 1'b0);	// store 1
		push_req(10'd790, 1'b1, 1'b0);	// digit 2 window high edge
		push_req(10'd739, 1'b0, 1'b0);
		push_req(10'd739, 1'b1, 1'b0);	// store 2
		push_req(10'd688, 1'b1, 1'b0);
		push_req(10'd637, 1'b0, 1'b0);
		push_req(10'd650, 1'b1, 1'b0);	// store 3
		push_req(10'd535, 1'b1, 1'b0);
		push_req(10'd586, 1'b0, 1'b0);
		push_req(10'd560, 1'b1, 1'b0);	// store 4: opens, no dismiss on same release
		push_req(10'd1023, 1'b0, 1'b0);
		push_req(10'd0, 1'b1, 1'b0);		// release dismisses the open state
		push_req(10'd101, 1'b1, 1'b0);	// last point of the lowest band
		push_req(10'd102, 1'b1, 1'b0);	// first point of the next band
		push_req(10'd968, 1'b1, 1'b0);	// top band window: digit 0, starts entry
		push_req(10'd998, 1'b1, 1'b0);
		settle(4);

		// Limit 1 with no dead band: only correct codes get through.
		burst_odds = 20;
		program_lock(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
			4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), 4'd1, 6'd0);
		run_phase(200);

		// Widest legal dead band, extreme digits; receiver holds off long enough to back
		// the block up while requests keep coming.
		program_lock(4'd9, 4'd0, 4'd9, 4'd0, 4'd15, 6'd50);
		squeeze_asked++;
		run_phase(250);

		// Dead band past every band: no sample is ever accepted.
		burst_odds = 30;
		write_reg(REG_DEAD_BAND, 6'd63);
		run_phase(60);

		for (int k = 0; k < 4; k++) begin
			burst_odds = (k == 1) ? 0 : 10 + 10 * k;
			lim_lo = (plan_st.tally + 2 > 15) ? 15 : plan_st.tally + 2;
			program_lock(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
				4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
				4'($urandom_range(lim_lo, 15)), 6'($urandom_range(0, 50)));
			run_phase(220);
		end

		// Last part, no idling: limit dropped to zero, at or below the tally, so the next
		// wrong code locks out with the tally left as is; then the lock stays shut.
		burst_odds = 0;
		write_reg(REG_LIMIT, 6'd0);
		write_reg(REG_DEAD_BAND, 6'(DEAD_BAND_RST));
		lockout_ok = 1'b1;
		force_wrong = 1'b1;
		run_phase(150);
		settle(6);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dcl_pkg.sv
hw/rtl/dial_code_lock.sv
bench/tb.sv
